// ===== design/ssf_pkg.sv =====
`timescale 1ns / 1ps

package ssf_pkg;

  // Path count capacity; a kept notification path is at most one byte shorter than this.
  localparam int PATH_CAP_DEF = 256;

  // Result kinds.
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_PATH = 2'd1;
  localparam logic [1:0] KIND_LEND = 2'd2;

  // Escape phases. The unused code behaves as plain text.
  localparam logic [1:0] ESC_PLAIN = 2'd0;
  localparam logic [1:0] ESC_HELD  = 2'd1;
  localparam logic [1:0] ESC_CSI   = 2'd2;

  // Prompt matcher phases: 1..6 count prefix letters matched.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_FIRST = 4'd1;
  localparam logic [3:0] PH_LAST_LETTER = 4'd5;
  localparam logic [3:0] PH_WORD  = 4'd6;
  localparam logic [3:0] PH_CWD   = 4'd7;
  localparam logic [3:0] PH_GT    = 4'd8;

  // Character codes.
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_TILDE    = 8'h7e;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_GT       = 8'h3e;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_Z     = 8'h5a;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_Z     = 8'h7a;

  // The six-letter word that opens a shell prompt.
  localparam logic [7:0] PROMPT_WORD [6] = '{8'h74, 8'h69, 8'h6b, 8'h75, 8'h4f, 8'h53};

  // Filter state other than the path count.
  typedef struct packed {
    logic [1:0] esc_phase;
    logic       in_notify;
    logic       line_start;
    logic       held_cr;
    logic [3:0] prompt_phase;
  } st_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       prompt_end;
    logic       last;
  } res_t;

  // Prompt matcher step: returns {hit, next phase}.
  function automatic logic [4:0] prompt_next(input logic [3:0] p_in, input logic [7:0] c);
    logic [3:0] p;
    logic [3:0] rs;
    logic       hit;
    p   = p_in;
    hit = 1'b0;
    rs  = (c == PROMPT_WORD[0]) ? PH_FIRST : PH_IDLE;
    if (p > PH_GT) begin
      p = PH_IDLE;
    end
    if (p <= PH_LAST_LETTER) begin
      p = (c == PROMPT_WORD[p[2:0]]) ? p + 4'd1 : rs;
    end else if (p == PH_WORD) begin
      if (c == CH_COLON) begin
        p = PH_CWD;
      end else if (c == CH_GT) begin
        p = PH_GT;
      end else begin
        p = rs;
      end
    end else if (p == PH_CWD) begin
      if (c == CH_GT) begin
        p = PH_GT;
      end else if (c == CH_LF) begin
        p = PH_IDLE;
      end
    end else begin
      if (c == CH_SPACE) begin
        hit = 1'b1;
        p   = PH_IDLE;
      end else begin
        p = rs;
      end
    end
    return {hit, p};
  endfunction

endpackage

// ===== design/ssf_step.sv =====
`timescale 1ns / 1ps

// Combinational work for one received byte: escape stripping, notification
// split and prompt matching. Produces up to three result items and the next
// state.
module ssf_step #(
  parameter int PATH_CAP = ssf_pkg::PATH_CAP_DEF,
  localparam int CW = $clog2(PATH_CAP)
) (
  input  logic [7:0]             byte_i,
  input  ssf_pkg::st_t           st_i,
  input  logic [CW-1:0]          cnt_i,
  input  logic [CW-1:0]          lim_i,
  output ssf_pkg::st_t           st_o,
  output logic [CW-1:0]          cnt_o,
  output ssf_pkg::res_t [2:0]    res_o,
  output logic [1:0]             n_o
);

  typedef struct packed {
    ssf_pkg::st_t          st;
    logic [CW-1:0]         cnt;
    ssf_pkg::res_t [2:0]   res;
    logic [1:0]            n;
  } ctx_t;

  // Append one result item.
  function automatic ctx_t put(input ctx_t x, input logic [1:0] k, input logic [7:0] c,
                               input logic pe);
    ctx_t y;
    y = x;
    if (x.n != 2'd3) begin
      y.res[x.n] = '{kind: k, data: c, prompt_end: pe, last: 1'b0};
      y.n = x.n + 2'd1;
    end
    return y;
  endfunction

  // Path byte, kept only while the line is under its limit.
  function automatic ctx_t path_byte(input ctx_t x, input logic [7:0] c,
                                     input logic [CW-1:0] lim);
    ctx_t y;
    y = x;
    if (x.cnt < lim) begin
      y = put(x, ssf_pkg::KIND_PATH, c, 1'b0);
      y.cnt = x.cnt + 1'b1;
    end
    return y;
  endfunction

  // Second stage: notification lines versus text.
  function automatic ctx_t demux(input ctx_t x, input logic [7:0] c,
                                 input logic [CW-1:0] lim);
    ctx_t       y;
    logic [4:0] pf;
    y  = x;
    pf = '0;
    if (y.st.in_notify) begin
      if (c == ssf_pkg::CH_LF) begin
        y.st.held_cr    = 1'b0;
        y               = put(y, ssf_pkg::KIND_LEND, 8'h00, 1'b0);
        y.st.in_notify  = 1'b0;
        y.st.line_start = 1'b1;
        y.cnt           = '0;
      end else begin
        // A carriage return not followed by newline is part of the path.
        if (y.st.held_cr) begin
          y.st.held_cr = 1'b0;
          y = path_byte(y, ssf_pkg::CH_CR, lim);
        end
        if (c == ssf_pkg::CH_CR) begin
          y.st.held_cr = 1'b1;
        end else begin
          y = path_byte(y, c, lim);
        end
      end
    end else if (y.st.line_start && (c == ssf_pkg::CH_TILDE)) begin
      y.st.in_notify  = 1'b1;
      y.st.held_cr    = 1'b0;
      y.cnt           = '0;
      y.st.line_start = 1'b0;
    end else begin
      y.st.line_start   = (c == ssf_pkg::CH_LF);
      pf                = ssf_pkg::prompt_next(y.st.prompt_phase, c);
      y.st.prompt_phase = pf[3:0];
      y = put(y, ssf_pkg::KIND_TEXT, c, pf[4]);
    end
    return y;
  endfunction

  logic is_letter;

  assign is_letter = ((byte_i >= ssf_pkg::CH_UP_A) && (byte_i <= ssf_pkg::CH_UP_Z)) ||
                     ((byte_i >= ssf_pkg::CH_LO_A) && (byte_i <= ssf_pkg::CH_LO_Z));

  // First stage: escape handling, then the second stage up to twice.
  always_comb begin
    ctx_t x;
    x.st  = st_i;
    x.cnt = cnt_i;
    x.res = '0;
    x.n   = 2'd0;
    case (st_i.esc_phase)
      ssf_pkg::ESC_HELD: begin
        if (byte_i == ssf_pkg::CH_LBRACKET) begin
          x.st.esc_phase = ssf_pkg::ESC_CSI;
        end else if (byte_i == ssf_pkg::CH_ESC) begin
          x = demux(x, ssf_pkg::CH_ESC, lim_i);
        end else begin
          x.st.esc_phase = ssf_pkg::ESC_PLAIN;
          x = demux(x, ssf_pkg::CH_ESC, lim_i);
          x = demux(x, byte_i, lim_i);
        end
      end
      ssf_pkg::ESC_CSI: begin
        if (is_letter) begin
          x.st.esc_phase = ssf_pkg::ESC_PLAIN;
        end
      end
      default: begin
        if (byte_i == ssf_pkg::CH_ESC) begin
          x.st.esc_phase = ssf_pkg::ESC_HELD;
        end else begin
          x.st.esc_phase = ssf_pkg::ESC_PLAIN;
          x = demux(x, byte_i, lim_i);
        end
      end
    endcase
    // Mark the final item of this byte.
    if (x.n != 2'd0) begin
      x.res[x.n - 2'd1].last = 1'b1;
    end
    st_o  = x.st;
    cnt_o = x.cnt;
    res_o = x.res;
    n_o   = x.n;
  end

endmodule

// ===== design/shell_stream_filter.sv =====
// An accepted byte is held in the input register, then its items move into the
// result buffer once it is free, and the first item is presented from there.
// Throughput: one byte per cycle when each byte yields at most one item and the
// receiver does not stall; a byte that yields several items holds the input while
// its items drain from the three-entry result buffer, one per cycle when ready.
// Reset (synchronous, active low) clears the filter state and sets path_limit to 255.
`timescale 1ns / 1ps

module shell_stream_filter #(
  parameter int PATH_CAP = ssf_pkg::PATH_CAP_DEF,
  localparam int CW = $clog2(PATH_CAP)
) (
  input  logic       clk,
  input  logic       rst_n,
  // Received bytes.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  // Result items.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_out
  output logic [2:0] out_tuser,  // [1:0] kind, [2] prompt_end
  output logic       out_tlast,
  // path_limit register write.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam logic [7:0] CAP_M1 = 8'(PATH_CAP - 1);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic [7:0]            path_limit_r;
  ssf_pkg::st_t          st_r;
  logic [CW-1:0]         cnt_r;
  ssf_pkg::res_t [2:0]   res_r;
  logic [1:0]            n_r;
  logic [1:0]            pos_r;

  ssf_pkg::st_t          st_nxt;
  logic [CW-1:0]         cnt_nxt;
  ssf_pkg::res_t [2:0]   res_nxt;
  logic [1:0]            n_nxt;
  logic [CW-1:0]         lim;
  logic                  out_fire;
  logic                  buf_free;
  logic                  load;
  ssf_pkg::res_t         cur;

  // Effective limit is the smaller of the register and the largest count value, PATH_CAP - 1.
  assign lim = (path_limit_r > CAP_M1) ? CAP_M1[CW-1:0] : path_limit_r[CW-1:0];

  ssf_step #(
    .PATH_CAP(PATH_CAP)
  ) u_step (
    .byte_i (s1_byte_r),
    .st_i   (st_r),
    .cnt_i  (cnt_r),
    .lim_i  (lim),
    .st_o   (st_nxt),
    .cnt_o  (cnt_nxt),
    .res_o  (res_nxt),
    .n_o    (n_nxt)
  );

  // Handshake control.
  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = (pos_r == n_r) || (out_fire && ((pos_r + 2'd1) == n_r));
  assign load      = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || load;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_limit_r <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      path_limit_r <= cfg_data;
    end
  end

  // Filter state advances when a byte moves into the result buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{esc_phase: ssf_pkg::ESC_PLAIN, in_notify: 1'b0, line_start: 1'b1,
                 held_cr: 1'b0, prompt_phase: ssf_pkg::PH_IDLE};
      cnt_r <= '0;
    end else if (load) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result buffer and its read pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= 2'd0;
      pos_r <= 2'd0;
    end else if (load) begin
      n_r   <= n_nxt;
      pos_r <= 2'd0;
    end else if (out_fire) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  // Output selection.
  always_comb begin
    case (pos_r)
      2'd1:    cur = res_r[1];
      2'd2:    cur = res_r[2];
      default: cur = res_r[0];
    endcase
  end

  assign out_tvalid = (pos_r != n_r);
  assign out_tdata  = cur.data;
  assign out_tuser  = {cur.prompt_end, cur.kind};
  assign out_tlast  = cur.last;

  // The read pointer never runs past the item count.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= n_r)
    else $error("result read pointer beyond item count");

  // The final item of a byte, and only it, carries tlast.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == ((pos_r + 2'd1) == n_r)))
    else $error("tlast not on final item");

  // A prompt flag only ever marks a text byte.
  a_prompt_text: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == ssf_pkg::KIND_TEXT))
    else $error("prompt flag on non-text item");

  // Bytes inside an escape sequence yield nothing.
  a_csi_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (st_r.esc_phase == ssf_pkg::ESC_CSI)) |-> (n_nxt == 2'd0))
    else $error("result from byte inside escape sequence");

  // A loaded byte with results shows one on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (n_nxt != 2'd0)) |=> out_tvalid)
    else $error("loaded results not presented");

endmodule

// ===== test/ssf_filter_checker.sv =====
`timescale 1ns / 1ps

module ssf_filter_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [2:0] out_tuser,
  input  logic       out_tlast,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         n_fail,
  output int         n_pending
);

  // One result item as the block should produce it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       pe;
    logic       last;
  } filt_item_t;

  // Predicted filter state and the path limit register.
  logic [1:0] esc_st;
  logic       in_note;
  logic       line_head;
  logic       cr_held;
  logic [7:0] path_cnt;
  logic [3:0] pr_ph;
  logic [7:0] path_lim;

  filt_item_t byte_items[$];
  filt_item_t cleaned_q[$];
  filt_item_t got;
  filt_item_t want;
  int         fails = 0;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= ssf_pkg::CH_UP_A && c <= ssf_pkg::CH_UP_Z) ||
           (c >= ssf_pkg::CH_LO_A && c <= ssf_pkg::CH_LO_Z);
  endfunction

  function automatic void emit(input logic [1:0] k, input logic [7:0] d, input logic p);
    filt_item_t r;
    r.kind = k;
    r.data = d;
    r.pe   = p;
    r.last = 1'b0;
    byte_items.push_back(r);
  endfunction

  // Prompt matcher: advances pr_ph and reports when a prompt is complete.
  function automatic logic prompt_step(input logic [7:0] c);
    logic [3:0] ph;
    logic [3:0] restart;
    logic       hit;
    hit     = 1'b0;
    restart = (c == ssf_pkg::PROMPT_WORD[0]) ? ssf_pkg::PH_FIRST : ssf_pkg::PH_IDLE;
    ph      = (pr_ph > ssf_pkg::PH_GT) ? ssf_pkg::PH_IDLE : pr_ph;
    if (ph <= ssf_pkg::PH_LAST_LETTER) begin
      ph = (c == ssf_pkg::PROMPT_WORD[ph]) ? ph + 4'd1 : restart;
    end else begin
      case (ph)
        ssf_pkg::PH_WORD: begin
          if (c == ssf_pkg::CH_COLON) ph = ssf_pkg::PH_CWD;
          else if (c == ssf_pkg::CH_GT) ph = ssf_pkg::PH_GT;
          else ph = restart;
        end
        ssf_pkg::PH_CWD: begin
          if (c == ssf_pkg::CH_GT) ph = ssf_pkg::PH_GT;
          else if (c == ssf_pkg::CH_LF) ph = ssf_pkg::PH_IDLE;
        end
        default: begin
          if (c == ssf_pkg::CH_SPACE) begin
            hit = 1'b1;
            ph  = ssf_pkg::PH_IDLE;
          end else begin
            ph = restart;
          end
        end
      endcase
    end
    pr_ph = ph;
    return hit;
  endfunction

  // With the default capacity the limit never exceeds 255, so the register
  // value is the limit in use.
  function automatic void keep_path(input logic [7:0] c);
    if (path_cnt < path_lim) begin
      emit(ssf_pkg::KIND_PATH, c, 1'b0);
      path_cnt = path_cnt + 8'd1;
    end
  endfunction

  // Second stage: notification lines versus plain text.
  function automatic void split_line(input logic [7:0] c);
    logic hit;
    if (in_note) begin
      if (c == ssf_pkg::CH_LF) begin
        cr_held   = 1'b0;
        emit(ssf_pkg::KIND_LEND, 8'h00, 1'b0);
        in_note   = 1'b0;
        line_head = 1'b1;
        path_cnt  = 8'd0;
      end else begin
        if (cr_held) begin
          cr_held = 1'b0;
          keep_path(ssf_pkg::CH_CR);
        end
        if (c == ssf_pkg::CH_CR) cr_held = 1'b1;
        else keep_path(c);
      end
    end else if (line_head && c == ssf_pkg::CH_TILDE) begin
      in_note   = 1'b1;
      cr_held   = 1'b0;
      path_cnt  = 8'd0;
      line_head = 1'b0;
    end else begin
      line_head = (c == ssf_pkg::CH_LF);
      hit = prompt_step(c);
      emit(ssf_pkg::KIND_TEXT, c, hit);
    end
  endfunction

  // First stage: CSI removal and the held escape byte.
  function automatic void filter_byte(input logic [7:0] c);
    case (esc_st)
      ssf_pkg::ESC_HELD: begin
        if (c == ssf_pkg::CH_LBRACKET) begin
          esc_st = ssf_pkg::ESC_CSI;
        end else if (c == ssf_pkg::CH_ESC) begin
          split_line(ssf_pkg::CH_ESC);
        end else begin
          esc_st = ssf_pkg::ESC_PLAIN;
          split_line(ssf_pkg::CH_ESC);
          split_line(c);
        end
      end
      ssf_pkg::ESC_CSI: begin
        if (is_letter(c)) esc_st = ssf_pkg::ESC_PLAIN;
      end
      default: begin
        if (c == ssf_pkg::CH_ESC) begin
          esc_st = ssf_pkg::ESC_HELD;
        end else begin
          esc_st = ssf_pkg::ESC_PLAIN;
          split_line(c);
        end
      end
    endcase
  endfunction

  // Track register writes and accepted bytes, and compare each result item.
  always @(posedge clk) begin
    if (!rst_n) begin
      esc_st    = ssf_pkg::ESC_PLAIN;
      in_note   = 1'b0;
      line_head = 1'b1;
      cr_held   = 1'b0;
      path_cnt  = 8'd0;
      pr_ph     = ssf_pkg::PH_IDLE;
      path_lim  = 8'd255;
      cleaned_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        path_lim = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        byte_items.delete();
        filter_byte(in_tdata);
        for (int i = 0; i < byte_items.size(); i++) begin
          want      = byte_items[i];
          want.last = (i == byte_items.size() - 1);
          cleaned_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[1:0];
        got.pe   = out_tuser[2];
        got.data = out_tdata;
        got.last = out_tlast;
        if (cleaned_q.size() == 0) begin
          fails = fails + 1;
          if (fails <= 10) begin
            $display("%0t: unexpected item kind %0d data %02h pe %b last %b",
                     $realtime, got.kind, got.data, got.pe, got.last);
          end
        end else begin
          want = cleaned_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.pe !== want.pe || got.last !== want.last) begin
            fails = fails + 1;
            if (fails <= 10) begin
              $display("%0t: item mismatch: expected kind %0d data %02h pe %b last %b,",
                       $realtime, want.kind, want.data, want.pe, want.last);
              $display("  got kind %0d data %02h pe %b last %b",
                       got.kind, got.data, got.pe, got.last);
            end
          end
        end
      end
    end
    n_pending <= cleaned_q.size();
    n_fail    <= fails;
  end

endmodule

// ===== test/tb_shell_stream_filter.sv =====
`timescale 1ns / 1ps

module tb_shell_stream_filter;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_PAD  = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  int n_fail;
  int n_pending;
  int n_sent = 0;
  int burst_left = 0;
  int cyc = 0;
  int rx_cnt = 0;
  int rx_mode = 0;

  shell_stream_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ssf_filter_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Overall watchdog.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver backpressure: rx_mode picks one of four ready patterns, redrawn at random as rx_cnt advances.
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_cnt / 4) % 2 == 0);
    endcase
  end

  // Send one byte, with bursts and random gaps between them.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left = burst_left - 1;
    n_sent     = n_sent + 1;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // First n letters of the prompt word.
  task automatic put_word(input int n);
    for (int i = 0; i < n; i++) put_byte(ssf_pkg::PROMPT_WORD[i]);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // Stop feeding and wait until every expected item has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A notification line with a path of len bytes.
  task automatic put_long_path(input int len);
    put_byte(ssf_pkg::CH_LF);
    put_byte(ssf_pkg::CH_TILDE);
    for (int i = 0; i < len; i++) put_byte(printable());
    put_byte(ssf_pkg::CH_LF);
  endtask

  // One random fragment of console traffic, mostly well formed.
  task automatic put_chunk();
    int k;
    int n;
    logic [7:0] b;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: begin
        // Plain text line.
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) put_byte(printable());
        if ($urandom_range(0, 2) == 0) put_byte(ssf_pkg::CH_CR);
        put_byte(ssf_pkg::CH_LF);
      end
      2, 3: begin
        // Notification line, sometimes with stray carriage returns.
        if ($urandom_range(0, 1) == 0) put_byte(ssf_pkg::CH_LF);
        put_byte(ssf_pkg::CH_TILDE);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          put_byte(($urandom_range(0, 7) == 0) ? ssf_pkg::CH_CR : printable());
        end
        case ($urandom_range(0, 7))
          0, 1, 2, 3: begin
            put_byte(ssf_pkg::CH_CR);
            put_byte(ssf_pkg::CH_LF);
          end
          4, 5: put_byte(ssf_pkg::CH_LF);
          6: begin
            put_byte(ssf_pkg::CH_CR);
            put_byte(ssf_pkg::CH_CR);
            put_byte(ssf_pkg::CH_LF);
          end
          default: ;
        endcase
      end
      4: begin
        // Prompt, full or broken.
        if ($urandom_range(0, 5) == 0) begin
          put_word($urandom_range(1, 5));
          put_byte(printable());
        end
        put_word(6);
        case ($urandom_range(0, 7))
          0, 1, 2, 3: put_text("> ");
          4, 5: begin
            put_byte(ssf_pkg::CH_COLON);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) put_byte(printable());
            put_text("> ");
          end
          6: put_text(">x");
          default: put_text("$ ");
        endcase
      end
      5: begin
        // CSI sequence, sometimes with junk before the final letter.
        put_byte(ssf_pkg::CH_ESC);
        put_byte(ssf_pkg::CH_LBRACKET);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) put_byte(8'($urandom_range(8'h80, 8'hff)));
          else put_byte(($urandom_range(0, 3) == 0) ? 8'h3b
                                                    : 8'($urandom_range(8'h30, 8'h39)));
        end
        put_byte(($urandom_range(0, 1) == 0)
                 ? 8'($urandom_range(ssf_pkg::CH_UP_A, ssf_pkg::CH_UP_Z))
                 : 8'($urandom_range(ssf_pkg::CH_LO_A, ssf_pkg::CH_LO_Z)));
      end
      6: begin
        // Lone escape followed by something other than a bracket, mostly.
        put_byte(ssf_pkg::CH_ESC);
        case ($urandom_range(0, 4))
          0: put_byte(ssf_pkg::CH_ESC);
          1: put_byte(ssf_pkg::CH_TILDE);
          2: put_byte(ssf_pkg::CH_LF);
          default: put_byte(8'($urandom_range(0, 255)));
        endcase
      end
      7: begin
        // Raw noise over the full byte range.
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
      end
      8: begin
        // Newline inside the working directory abandons the prompt.
        put_word(6);
        put_byte(ssf_pkg::CH_COLON);
        put_text("ab");
        put_byte(ssf_pkg::CH_LF);
        put_text("> ");
      end
      default: begin
        // Escapes and prompt bytes inside a notification line.
        put_byte(ssf_pkg::CH_LF);
        put_byte(ssf_pkg::CH_TILDE);
        put_text("/p");
        put_byte(ssf_pkg::CH_ESC);
        b = ($urandom_range(0, 1) == 0) ? ssf_pkg::CH_LBRACKET : printable();
        put_byte(b);
        put_text("1m");
        put_word(6);
        put_text("> ");
        put_byte(ssf_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = n_sent + count;
    while (n_sent < stop_at) put_chunk();
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset limit.
    put_byte(8'h00);
    put_byte(8'hff);
    put_text("\033[1m");
    put_text("\033x");
    put_text("\033\033a");
    put_byte(ssf_pkg::CH_LF);
    put_text("~p\rq\r\n");
    put_word(6);
    put_text("> ");
    run_random(25);
    settle();

    set_limit(8'd3);
    run_random(25);
    settle();

    set_limit(8'd0);
    run_random(20);
    settle();

    set_limit(8'd1);
    run_random(20);
    settle();

    set_limit(8'd128);
    run_random(20);
    settle();

    set_limit(8'($urandom_range(2, 254)));
    run_random(20);
    settle();

    set_limit(8'd255);
    put_long_path(258);
    run_random(15);
    settle();

    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
